// ----- rtl/core/mpec_pkg.sv -----
// ----------------------------------------------------------------------------
// mpec_pkg: shared definitions for the memory pattern error checker
// Field widths, saturation limits, register map, the population count
// function and the types that travel between the checker's modules.
// ----------------------------------------------------------------------------
package mpec_pkg;

   // Default geometry of a checked row.
   localparam int LINES_PER_ROW_DEFAULT  = 128;
   localparam int WORDS_PER_LINE_DEFAULT = 16;
   localparam int MAX_RECORDS_DEFAULT    = 32;

   // Fixed widths of the request and response fields.
   localparam int DATA_W       = 32;
   localparam int BITS_W       = 6;
   localparam int LINE_IDX_W   = 7;
   localparam int WORD_IDX_W   = 4;
   localparam int SLOT_W       = 5;
   localparam int MISMATCH_W   = 12;
   localparam int BITERR_W     = 17;

   // Totals saturate at the largest value of their fields.
   localparam logic [MISMATCH_W-1:0] MISMATCH_MAX = '1;
   localparam logic [BITERR_W-1:0]   BITERR_MAX   = '1;

   // Register map.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_EXPECTED_PATTERN = '0;

   // Request as held in the input stage.
   typedef struct packed {
      logic [DATA_W-1:0] read_word;
      logic              restart;
   } item_type;

   // Response as computed by the check unit and held in the output stage.
   typedef struct packed {
      logic                  mismatch;
      logic [BITS_W-1:0]     bits_wrong;
      logic [LINE_IDX_W-1:0] line_index;
      logic [WORD_IDX_W-1:0] word_index;
      logic [DATA_W-1:0]     actual_word;
      logic                  record_logged;
      logic [SLOT_W-1:0]     record_slot;
      logic [MISMATCH_W-1:0] mismatched_words;
      logic [BITERR_W-1:0]   bit_errors;
      logic                  row_done;
   } result_type;

   // Population count of a 32-bit word: nibble counts, then their sum.
   function automatic logic [BITS_W-1:0] popcount32(input logic [DATA_W-1:0] value);
      logic [2:0]        nib [DATA_W/4];
      logic [BITS_W-1:0] sum;
      sum = '0;
      for (int n = 0; n < DATA_W/4; n++) begin
         nib[n] = 3'({2'b00, value[4*n]}) + 3'({2'b00, value[4*n+1]})
                + 3'({2'b00, value[4*n+2]}) + 3'({2'b00, value[4*n+3]});
      end
      for (int n = 0; n < DATA_W/4; n++) begin
         sum = sum + BITS_W'(nib[n]);
      end
      return sum;
   endfunction

endpackage

// ----- rtl/core/mpec_csr.sv -----
// ----------------------------------------------------------------------------
// mpec_csr: configuration register port
// Holds the expected pattern, written and read over the APB-style port.
// ----------------------------------------------------------------------------
module mpec_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mpec_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mpec_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mpec_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output logic [mpec_pkg::DATA_W-1:0]        expected_pattern
);

   logic [mpec_pkg::DATA_W-1:0] pattern_ff;
   logic [mpec_pkg::DATA_W-1:0] pattern_in;
   logic                        hit_pattern;

   // Byte offsets within one word are ignored.
   assign hit_pattern = (paddr[mpec_pkg::CSR_ADDR_W-1:2] == mpec_pkg::REG_EXPECTED_PATTERN);

   always_comb begin
      pattern_in = pattern_ff;
      if (psel && penable && pwrite && hit_pattern) begin
         pattern_in = pwdata[mpec_pkg::DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
      end else begin
         pattern_ff <= pattern_in;
      end
   end

   assign prdata           = hit_pattern ? pattern_ff : '0;
   assign pready           = 1'b1;
   assign expected_pattern = pattern_ff;

endmodule

// ----- rtl/core/mpec_in_stage.sv -----
// ----------------------------------------------------------------------------
// mpec_in_stage: request input register
// Captures one request per cycle unless stalled, holds it until the check unit takes it.
// ----------------------------------------------------------------------------
module mpec_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [mpec_pkg::DATA_W-1:0] req_read_word,
   input  logic                       req_restart,
   input  logic                       out_ready,
   output logic                       item_valid,
   output mpec_pkg::item_type         item
);

   logic               valid_ff;
   logic               valid_in;
   mpec_pkg::item_type item_ff;
   logic               take;
   logic               advance;

   assign advance   = valid_ff && out_ready;
   assign req_stall = valid_ff && !out_ready;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.read_word <= req_read_word;
         item_ff.restart   <= req_restart;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/core/mpec_check.sv -----
// ----------------------------------------------------------------------------
// mpec_check: compare, count and position unit
// Compares the held word with the pattern and keeps the row counters.
// ----------------------------------------------------------------------------
module mpec_check #(
   parameter int LINES_PER_ROW  = mpec_pkg::LINES_PER_ROW_DEFAULT,
   parameter int WORDS_PER_LINE = mpec_pkg::WORDS_PER_LINE_DEFAULT,
   parameter int MAX_RECORDS    = mpec_pkg::MAX_RECORDS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  mpec_pkg::item_type          item,
   input  logic [mpec_pkg::DATA_W-1:0] expected_pattern,
   output mpec_pkg::result_type        result
);

   localparam int LINE_W = (LINES_PER_ROW  > 1) ? $clog2(LINES_PER_ROW)  : 1;
   localparam int WORD_W = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
   localparam int REC_W  = $clog2(MAX_RECORDS + 1);
   localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(LINES_PER_ROW - 1);
   localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(WORDS_PER_LINE - 1);
   localparam logic [REC_W-1:0]  REC_FULL  = REC_W'(MAX_RECORDS);

   logic [LINE_W-1:0]               line_ff, line_in, line_cur;
   logic [WORD_W-1:0]               word_ff, word_in, word_cur;
   logic [mpec_pkg::MISMATCH_W-1:0] mis_ff, mis_in, mis_cur, mis_new;
   logic [mpec_pkg::BITERR_W-1:0]   err_ff, err_in, err_cur, err_new;
   logic [REC_W-1:0]                rec_ff, rec_in, rec_cur;
   logic [mpec_pkg::BITERR_W:0]     err_sum;
   logic [mpec_pkg::DATA_W-1:0]     diff;
   logic [mpec_pkg::BITS_W-1:0]     bits;
   logic                            miss;
   logic                            logged;
   logic                            done;
   logic                            last_word;
   logic [LINE_W+mpec_pkg::LINE_IDX_W-1:0] line_wide;
   logic [WORD_W+mpec_pkg::WORD_IDX_W-1:0] word_wide;
   logic [REC_W+mpec_pkg::SLOT_W-1:0]      slot_wide;

   // A restarting word sees a freshly cleared row.
   assign line_cur = item.restart ? '0 : line_ff;
   assign word_cur = item.restart ? '0 : word_ff;
   assign mis_cur  = item.restart ? '0 : mis_ff;
   assign err_cur  = item.restart ? '0 : err_ff;
   assign rec_cur  = item.restart ? '0 : rec_ff;

   assign diff   = item.read_word ^ expected_pattern;
   assign miss   = |diff;
   assign bits   = mpec_pkg::popcount32(diff);
   assign logged = miss && (rec_cur != REC_FULL);

   assign last_word = (word_cur == LAST_WORD);
   assign done      = last_word && (line_cur == LAST_LINE);

   always_comb begin
      mis_new = mis_cur;
      if (miss && (mis_cur != mpec_pkg::MISMATCH_MAX)) begin
         mis_new = mis_cur + 1'b1;
      end
      err_sum = {1'b0, err_cur} + (mpec_pkg::BITERR_W + 1)'(bits);
      err_new = err_sum[mpec_pkg::BITERR_W] ? mpec_pkg::BITERR_MAX
                                            : err_sum[mpec_pkg::BITERR_W-1:0];
   end

   // Next row state: a finished row clears, otherwise the position steps on.
   always_comb begin
      line_in = line_cur;
      word_in = word_cur + 1'b1;
      mis_in  = mis_new;
      err_in  = err_new;
      rec_in  = logged ? rec_cur + 1'b1 : rec_cur;
      if (done) begin
         line_in = '0;
         word_in = '0;
         mis_in  = '0;
         err_in  = '0;
         rec_in  = '0;
      end else if (last_word) begin
         line_in = line_cur + 1'b1;
         word_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
         word_ff <= '0;
         mis_ff  <= '0;
         err_ff  <= '0;
         rec_ff  <= '0;
      end else if (advance) begin
         line_ff <= line_in;
         word_ff <= word_in;
         mis_ff  <= mis_in;
         err_ff  <= err_in;
         rec_ff  <= rec_in;
      end
   end

   // Positions and slot are cut or padded to their field widths.
   assign line_wide = {{mpec_pkg::LINE_IDX_W{1'b0}}, line_cur};
   assign word_wide = {{mpec_pkg::WORD_IDX_W{1'b0}}, word_cur};
   assign slot_wide = {{mpec_pkg::SLOT_W{1'b0}}, (logged ? rec_cur : {REC_W{1'b0}})};

   always_comb begin
      result.mismatch         = miss;
      result.bits_wrong       = bits;
      result.line_index       = line_wide[mpec_pkg::LINE_IDX_W-1:0];
      result.word_index       = word_wide[mpec_pkg::WORD_IDX_W-1:0];
      result.actual_word      = item.read_word;
      result.record_logged    = logged;
      result.record_slot      = slot_wide[mpec_pkg::SLOT_W-1:0];
      result.mismatched_words = mis_new;
      result.bit_errors       = err_new;
      result.row_done         = done;
   end

endmodule

// ----- rtl/core/memory_pattern_error_checker.sv -----
// Path: an accepted request waits in the input register, is checked combinationally
// and moves into the response register, which drives the response ports.
// Throughput: one request per cycle unless stalled; the input and response registers
// let a new request in while a finished response waits under stall.
// Reset (synchronous, active high) empties both stages, clears the row position
// and all counters, and sets the expected pattern to zero.
// ----------------------------------------------------------------------------
// memory_pattern_error_checker: read-back pattern checker with error log
// Compares each read-back word of a memory row with the expected pattern
// and reports mismatch details, row position, running totals and record slots.
// ----------------------------------------------------------------------------
module memory_pattern_error_checker #(
   parameter int LINES_PER_ROW  = mpec_pkg::LINES_PER_ROW_DEFAULT,
   parameter int WORDS_PER_LINE = mpec_pkg::WORDS_PER_LINE_DEFAULT,
   parameter int MAX_RECORDS    = mpec_pkg::MAX_RECORDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [mpec_pkg::DATA_W-1:0]     req_read_word,
   input  logic                            req_restart,
   // Response channel.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_mismatch,
   output logic [mpec_pkg::BITS_W-1:0]     rsp_bits_wrong,
   output logic [mpec_pkg::LINE_IDX_W-1:0] rsp_line_index,
   output logic [mpec_pkg::WORD_IDX_W-1:0] rsp_word_index,
   output logic [mpec_pkg::DATA_W-1:0]     rsp_actual_word,
   output logic                            rsp_record_logged,
   output logic [mpec_pkg::SLOT_W-1:0]     rsp_record_slot,
   output logic [mpec_pkg::MISMATCH_W-1:0] rsp_mismatched_words,
   output logic [mpec_pkg::BITERR_W-1:0]   rsp_bit_errors,
   output logic                            rsp_row_done,
   // Configuration port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mpec_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mpec_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mpec_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   logic [mpec_pkg::DATA_W-1:0] expected_pattern;
   logic                        item_valid;
   mpec_pkg::item_type          item;
   mpec_pkg::result_type        result;
   mpec_pkg::result_type        rsp_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        out_ready;
   logic                        advance;

   // The user must rewrite the expected pattern only while no request is in flight; the block does not enforce it.
   mpec_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .expected_pattern (expected_pattern)
   );

   // The response register can take a new result when it is empty or when
   // its current result leaves at this edge.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid && out_ready;

   mpec_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_read_word (req_read_word),
      .req_restart   (req_restart),
      .out_ready     (out_ready),
      .item_valid    (item_valid),
      .item          (item)
   );

   // The row counters advance exactly when a checked request moves into
   // the response register, so each request is counted once.
   mpec_check #(
      .LINES_PER_ROW  (LINES_PER_ROW),
      .WORDS_PER_LINE (WORDS_PER_LINE),
      .MAX_RECORDS    (MAX_RECORDS)
   ) u_check (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .item             (item),
      .expected_pattern (expected_pattern),
      .result           (result)
   );

   // Response register: loads on advance, holds while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mismatch         = rsp_ff.mismatch;
   assign rsp_bits_wrong       = rsp_ff.bits_wrong;
   assign rsp_line_index       = rsp_ff.line_index;
   assign rsp_word_index       = rsp_ff.word_index;
   assign rsp_actual_word      = rsp_ff.actual_word;
   assign rsp_record_logged    = rsp_ff.record_logged;
   assign rsp_record_slot      = rsp_ff.record_slot;
   assign rsp_mismatched_words = rsp_ff.mismatched_words;
   assign rsp_bit_errors       = rsp_ff.bit_errors;
   assign rsp_row_done         = rsp_ff.row_done;

endmodule

// ----- rtl/core/mpec_checker.sv -----
// ----------------------------------------------------------------------------
// mpec_checker: port-level assertions for the pattern checker
// Watches the response channel for consistent results and stable stalls.
// ----------------------------------------------------------------------------
module mpec_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_mismatch,
   input logic [mpec_pkg::BITS_W-1:0]     rsp_bits_wrong,
   input logic                            rsp_record_logged,
   input logic [mpec_pkg::SLOT_W-1:0]     rsp_record_slot,
   input logic [mpec_pkg::MISMATCH_W-1:0] rsp_mismatched_words,
   input logic [mpec_pkg::BITERR_W-1:0]   rsp_bit_errors
);

   // A reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // The mismatch flag agrees with the wrong-bit count.
   a_flag_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mismatch == (rsp_bits_wrong != '0)))
      else $error("mismatch flag disagrees with bit count");

   // A matching word takes no record slot.
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mismatch) |-> (!rsp_record_logged && rsp_record_slot == '0))
      else $error("record slot given to a matching word");

   // A logged record implies nonzero running totals.
   a_totals: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_record_logged) |->
         (rsp_mismatched_words != '0 && rsp_bit_errors != '0))
      else $error("record logged with zero totals");

   // A stalled response stays valid and keeps its running totals.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_bit_errors) && $stable(rsp_mismatched_words)))
      else $error("stalled response changed");

endmodule

bind memory_pattern_error_checker mpec_checker u_mpec_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_mismatch         (rsp_mismatch),
   .rsp_bits_wrong       (rsp_bits_wrong),
   .rsp_record_logged    (rsp_record_logged),
   .rsp_record_slot      (rsp_record_slot),
   .rsp_mismatched_words (rsp_mismatched_words),
   .rsp_bit_errors       (rsp_bit_errors)
);

// ----- test/mpec_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpec_result_checker: response predictor and comparator
// Watches the request, response and register ports of the pattern checker,
// keeps its own copy of the row counters and the expected pattern, and
// compares every response with the oldest predicted one.
// ----------------------------------------------------------------------------
module mpec_result_checker #(
   parameter int LINES_PER_ROW  = mpec_pkg::LINES_PER_ROW_DEFAULT,
   parameter int WORDS_PER_LINE = mpec_pkg::WORDS_PER_LINE_DEFAULT,
   parameter int MAX_RECORDS    = mpec_pkg::MAX_RECORDS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [mpec_pkg::DATA_W-1:0]     req_read_word,
   input  logic                            req_restart,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_mismatch,
   input  logic [mpec_pkg::BITS_W-1:0]     rsp_bits_wrong,
   input  logic [mpec_pkg::LINE_IDX_W-1:0] rsp_line_index,
   input  logic [mpec_pkg::WORD_IDX_W-1:0] rsp_word_index,
   input  logic [mpec_pkg::DATA_W-1:0]     rsp_actual_word,
   input  logic                            rsp_record_logged,
   input  logic [mpec_pkg::SLOT_W-1:0]     rsp_record_slot,
   input  logic [mpec_pkg::MISMATCH_W-1:0] rsp_mismatched_words,
   input  logic [mpec_pkg::BITERR_W-1:0]   rsp_bit_errors,
   input  logic                            rsp_row_done,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mpec_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mpec_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                            pready,
   output int                              failures,
   output int                              reports_owed
);

   localparam int DW        = mpec_pkg::DATA_W;
   localparam int ROW_WORDS = LINES_PER_ROW * WORDS_PER_LINE;
   localparam int POS_W     = $clog2(ROW_WORDS);
   localparam logic [mpec_pkg::CSR_ADDR_W-1:0] PATTERN_ADDR =
      mpec_pkg::CSR_ADDR_W'({mpec_pkg::REG_EXPECTED_PATTERN, 2'b00});

   logic [mpec_pkg::DATA_W-1:0]     pattern = '0;
   logic [POS_W-1:0]                word_pos = '0;
   logic [mpec_pkg::MISMATCH_W-1:0] miss_count = '0;
   logic [mpec_pkg::BITERR_W-1:0]   bit_total = '0;
   logic [6:0]                      slots_taken = '0;

   mpec_pkg::result_type expected_reports[$];

   function automatic void start_new_row();
      word_pos    = '0;
      miss_count  = '0;
      bit_total   = '0;
      slots_taken = '0;
   endfunction

   // Grades one read-back word and advances the row counters.
   function automatic mpec_pkg::result_type grade_word(
      input logic [mpec_pkg::DATA_W-1:0] word,
      input logic                        restart);
      mpec_pkg::result_type          r;
      logic [mpec_pkg::DATA_W-1:0]   diff;
      logic [mpec_pkg::BITERR_W:0]   sum;
      r = '0;
      if (restart)
         start_new_row();
      if (word_pos >= ROW_WORDS)
         word_pos = '0;
      r.line_index  = mpec_pkg::LINE_IDX_W'(int'(word_pos) / WORDS_PER_LINE);
      r.word_index  = mpec_pkg::WORD_IDX_W'(int'(word_pos) % WORDS_PER_LINE);
      r.actual_word = word;
      diff          = word ^ pattern;
      r.mismatch    = diff != '0;
      r.bits_wrong  = mpec_pkg::BITS_W'($countones(diff));
      if (r.mismatch) begin
         if (miss_count != mpec_pkg::MISMATCH_MAX)
            miss_count = miss_count + 1'b1;
         sum = {1'b0, bit_total} + (mpec_pkg::BITERR_W+1)'(r.bits_wrong);
         bit_total = (sum > mpec_pkg::BITERR_MAX) ? mpec_pkg::BITERR_MAX
                                                  : sum[mpec_pkg::BITERR_W-1:0];
         // Once every record slot is taken, mismatches still count but log nothing.
         if (slots_taken < MAX_RECORDS) begin
            r.record_logged = 1'b1;
            r.record_slot   = mpec_pkg::SLOT_W'(slots_taken);
            slots_taken     = slots_taken + 1'b1;
         end
      end
      r.mismatched_words = miss_count;
      r.bit_errors       = bit_total;
      r.row_done         = int'(word_pos) == ROW_WORDS - 1;
      if (r.row_done)
         start_new_row();
      else
         word_pos = word_pos + 1'b1;
      return r;
   endfunction

   function automatic void check_field(input string name,
                                       input logic [mpec_pkg::DATA_W-1:0] want,
                                       input logic [mpec_pkg::DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      mpec_pkg::result_type want;
      if (reset) begin
         start_new_row();
         pattern  = '0;
         failures = 0;
         expected_reports.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("response 0x%0h arrived with no request outstanding", rsp_actual_word);
               failures++;
            end else begin
               want = expected_reports.pop_front();
               check_field("mismatch", DW'(want.mismatch), DW'(rsp_mismatch));
               check_field("bits_wrong", DW'(want.bits_wrong), DW'(rsp_bits_wrong));
               check_field("line_index", DW'(want.line_index), DW'(rsp_line_index));
               check_field("word_index", DW'(want.word_index), DW'(rsp_word_index));
               check_field("actual_word", want.actual_word, rsp_actual_word);
               check_field("record_logged", DW'(want.record_logged),
                           DW'(rsp_record_logged));
               check_field("record_slot", DW'(want.record_slot), DW'(rsp_record_slot));
               check_field("mismatched_words", DW'(want.mismatched_words),
                           DW'(rsp_mismatched_words));
               check_field("bit_errors", DW'(want.bit_errors), DW'(rsp_bit_errors));
               check_field("row_done", DW'(want.row_done), DW'(rsp_row_done));
            end
         end
         if (req_valid && !req_stall)
            expected_reports.push_back(grade_word(req_read_word, req_restart));
         if (psel && penable && pwrite && pready && paddr == PATTERN_ADDR)
            pattern = pwdata;
      end
      reports_owed <= expected_reports.size();
   end

endmodule

// ----- test/memory_pattern_error_checker_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_pattern_error_checker_tb: regression bench for the pattern checker
// Drives read-back words and expected-pattern writes into the block, with
// random idling and stalling on both channels, and reports the verdict that
// the companion result checker reaches.
// ----------------------------------------------------------------------------
module memory_pattern_error_checker_tb;

   // Idling behavior of the two channels during a phase of the run.
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   localparam int ROW_WORDS      = mpec_pkg::LINES_PER_ROW_DEFAULT *
                                   mpec_pkg::WORDS_PER_LINE_DEFAULT;
   localparam int RANDOM_ITEMS   = 2100;
   localparam int PHASE_ITEMS    = 525;
   // The random part opens with short, often restarted rows; at this request a
   // restart begins one full row that runs without interruption to its end.
   localparam int LONG_ROW_START = 40;
   localparam int HOLD_CYCLES    = 80;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LIMIT_CYCLES   = 100000;
   localparam logic [mpec_pkg::CSR_ADDR_W-1:0] PATTERN_ADDR =
      mpec_pkg::CSR_ADDR_W'({mpec_pkg::REG_EXPECTED_PATTERN, 2'b00});

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [mpec_pkg::DATA_W-1:0]     req_read_word = '0;
   logic                            req_restart = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_mismatch;
   logic [mpec_pkg::BITS_W-1:0]     rsp_bits_wrong;
   logic [mpec_pkg::LINE_IDX_W-1:0] rsp_line_index;
   logic [mpec_pkg::WORD_IDX_W-1:0] rsp_word_index;
   logic [mpec_pkg::DATA_W-1:0]     rsp_actual_word;
   logic                            rsp_record_logged;
   logic [mpec_pkg::SLOT_W-1:0]     rsp_record_slot;
   logic [mpec_pkg::MISMATCH_W-1:0] rsp_mismatched_words;
   logic [mpec_pkg::BITERR_W-1:0]   rsp_bit_errors;
   logic                            rsp_row_done;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [mpec_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [mpec_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [mpec_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   int            failures;
   int            reports_owed;
   int            cycle_count = 0;
   idle_mode_type idle_mode = IDLE_NONE;
   logic          pressure_armed = 1'b0;
   logic          pressure_done = 1'b0;
   int            hold_left = 0;

   memory_pattern_error_checker DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_read_word        (req_read_word),
      .req_restart          (req_restart),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_mismatch         (rsp_mismatch),
      .rsp_bits_wrong       (rsp_bits_wrong),
      .rsp_line_index       (rsp_line_index),
      .rsp_word_index       (rsp_word_index),
      .rsp_actual_word      (rsp_actual_word),
      .rsp_record_logged    (rsp_record_logged),
      .rsp_record_slot      (rsp_record_slot),
      .rsp_mismatched_words (rsp_mismatched_words),
      .rsp_bit_errors       (rsp_bit_errors),
      .rsp_row_done         (rsp_row_done),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // The checker sees every port of the block but prdata and keeps the score.
   mpec_result_checker u_result_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_read_word        (req_read_word),
      .req_restart          (req_restart),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_mismatch         (rsp_mismatch),
      .rsp_bits_wrong       (rsp_bits_wrong),
      .rsp_line_index       (rsp_line_index),
      .rsp_word_index       (rsp_word_index),
      .rsp_actual_word      (rsp_actual_word),
      .rsp_record_logged    (rsp_record_logged),
      .rsp_record_slot      (rsp_record_slot),
      .rsp_mismatched_words (rsp_mismatched_words),
      .rsp_bit_errors       (rsp_bit_errors),
      .rsp_row_done         (rsp_row_done),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .pready               (pready),
      .failures             (failures),
      .reports_owed         (reports_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every run is bounded; reaching this limit means the block has hung.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Response side. Apart from the random stalls of the current phase, the
   // receiver holds off once for a long stretch at the first response seen
   // after pressure is armed. The sender keeps offering requests meanwhile,
   // so both stages fill up and the block has to stall its request channel.
   always @(posedge clock) begin
      int stall_pct;
      stall_pct = (idle_mode == IDLE_RECEIVER) ? 45 : (idle_mode == IDLE_BOTH) ? 18 : 0;
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (pressure_armed && !pressure_done && rsp_valid) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES - 1;
         pressure_done <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   // Offers one request and returns at the edge where the block takes it.
   // Idle cycles before the request depend on the phase; the payload stays put
   // while the block stalls.
   task automatic send_word(input logic [mpec_pkg::DATA_W-1:0] word,
                            input logic restart_bit);
      int gap_pct;
      gap_pct = (idle_mode == IDLE_SENDER) ? 45 : (idle_mode == IDLE_BOTH) ? 18 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_read_word <= word;
      req_restart   <= restart_bit;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops offering requests and waits until every response has come back.
   // The owed count is registered, so the task waits on the clock before it first looks.
   task automatic wait_for_reports();
      req_valid <= 1'b0;
      do @(posedge clock); while (reports_owed != 0);
   endtask

   // One register write: a setup phase, then an access phase that lasts until ready.
   task automatic write_pattern(input logic [mpec_pkg::DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PATTERN_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      logic [mpec_pkg::DATA_W-1:0] cur_pattern;
      logic [mpec_pkg::DATA_W-1:0] word;
      logic                        restart_bit;
      int                          phase;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, first against the pattern left by reset (all zeros).
      // A matching word must report no record and slot zero; the all-ones word
      // has every bit wrong; single bits at both ends follow.
      cur_pattern = '0;
      send_word(32'h0000_0000, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0001, 1'b0);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      // A restart in the middle of a row abandons it without a row end, here on
      // a mismatching word, and then a restart right after a restart.
      send_word(32'h1234_5678, 1'b1);
      send_word(32'h0000_0000, 1'b1);
      wait_for_reports();

      // The opposite extreme of the pattern register.
      cur_pattern = 32'hFFFF_FFFF;
      write_pattern(cur_pattern);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'h0000_0000, 1'b0);
      send_word(32'hFFFF_FFFE, 1'b0);
      send_word(32'h7FFF_FFFF, 1'b0);
      send_word(32'hFFFF_0000, 1'b1);

      // Random part in four phases, each with its own pattern and idling. The
      // long row reaches both the full record log and the end
      // of a row, after which counting wraps into a fresh row on its own.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            wait_for_reports();
            phase = n / PHASE_ITEMS;
            case (phase)
               0: begin
                  cur_pattern = $urandom;
                  idle_mode      <= IDLE_NONE;
                  pressure_armed <= 1'b1;
               end
               1: begin
                  cur_pattern = '0;
                  idle_mode <= IDLE_SENDER;
               end
               2: begin
                  cur_pattern = $urandom;
                  idle_mode <= IDLE_RECEIVER;
               end
               default: begin
                  cur_pattern = 32'hFFFF_FFFF ^ $urandom;
                  idle_mode <= IDLE_BOTH;
               end
            endcase
            write_pattern(cur_pattern);
         end

         if (n == LONG_ROW_START)
            restart_bit = 1'b1;
         else if (n > LONG_ROW_START && n < LONG_ROW_START + ROW_WORDS)
            restart_bit = 1'b0;
         else
            restart_bit = $urandom_range(11) == 0;

         // About half the words match; the rest flip one bit, many bits, all
         // bits, or are unrelated to the pattern.
         case ($urandom_range(9))
            0, 1, 2, 3, 4: word = cur_pattern;
            5, 6:          word = cur_pattern ^ (32'h1 << $urandom_range(31));
            7:             word = cur_pattern ^ $urandom;
            8:             word = ~cur_pattern;
            default:       word = $urandom;
         endcase
         send_word(word, restart_bit);
      end

      // Let the last responses drain, then watch a little longer for any
      // response that should not be there.
      wait_for_reports();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && reports_owed == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
